// ----- hw/rtl/jsu_pkg.sv -----
`default_nettype none
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_BAD_U     = 3'd2;
  localparam logic [2:0] ERR_BAD_LOW   = 3'd3;
  localparam logic [2:0] ERR_LONE_HIGH = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd5;
  localparam logic [2:0] ERR_CONTROL   = 3'd6;
  localparam logic [2:0] ERR_UNTERM    = 3'd7;

  // Surrogate ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // UTF-8 framing
  localparam logic [20:0] LIM_1B    = 21'h80;
  localparam logic [20:0] LIM_2B    = 21'h800;
  localparam logic [20:0] LIM_3B    = 21'h10000;
  localparam logic [7:0]  LEAD_2B   = 8'hC0;
  localparam logic [7:0]  LEAD_3B   = 8'hE0;
  localparam logic [7:0]  LEAD_4B   = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;
  localparam logic [7:0]  CTRL_LIM  = 8'h20;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // One group of 1..4 results caused by a single input word
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [2:0]      err;
    logic [3:0][7:0] bytes;
  } jsu_grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  function automatic jsu_hex_t hex_val(input logic [7:0] b);
    jsu_hex_t r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok = 1'b1;
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok = 1'b1;
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok = 1'b1;
      r.val = 4'(b - 8'h37);
    end
    return r;
  endfunction

  function automatic jsu_grp_t mk_err(input logic [2:0] code);
    jsu_grp_t g;
    g = '0;
    g.kind = KIND_ERR;
    g.err = code;
    return g;
  endfunction

  function automatic jsu_grp_t mk_close();
    jsu_grp_t g;
    g = '0;
    g.kind = KIND_CLOSE;
    return g;
  endfunction

  function automatic jsu_grp_t mk_byte(input logic [7:0] b);
    jsu_grp_t g;
    g = '0;
    g.kind = KIND_BYTE;
    g.bytes[0] = b;
    return g;
  endfunction

  function automatic jsu_grp_t mk_utf8(input logic [20:0] cp);
    jsu_grp_t g;
    g = '0;
    g.kind = KIND_BYTE;
    if (cp < LIM_1B) begin
      g.last_idx = 2'd0;
      g.bytes[0] = cp[7:0];
    end else if (cp < LIM_2B) begin
      g.last_idx = 2'd1;
      g.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
      g.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
    end else if (cp < LIM_3B) begin
      g.last_idx = 2'd2;
      g.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
      g.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      g.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
    end else begin
      g.last_idx = 2'd3;
      g.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
      g.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      g.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      g.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
`default_nettype none
module jsu_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             consume,
  input  wire logic [7:0]       b,
  input  wire logic             eoi,
  output logic                  emit,
  output jsu_pkg::jsu_grp_t     grp
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_BODY    = 7'b0000010,
    PH_ESC     = 7'b0000100,
    PH_HEX     = 7'b0001000,
    PH_LOW_BS  = 7'b0010000,
    PH_LOW_U   = 7'b0100000,
    PH_LOW_HEX = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] high_code, high_code_next;
  logic [15:0] low_code, low_code_next;
  logic [1:0]  hex_count, hex_count_next;
  logic        pending_bad_low, pending_bad_low_next;

  jsu_hex_t    hv;
  logic [20:0] pair_cp;

  assign hv = hex_val(b);

  always_comb begin
    phase_next           = phase;
    high_code_next       = high_code;
    low_code_next        = low_code;
    hex_count_next       = hex_count;
    pending_bad_low_next = pending_bad_low;
    emit                 = 1'b0;
    grp                  = '0;
    pair_cp              = '0;
    unique case (phase)
      PH_BODY: begin
        if (b == CH_QUOTE) begin
          phase_next = PH_IDLE;
          emit = 1'b1;
          grp = mk_close();
        end else if (b == CH_BSL) begin
          if (eoi) begin
            emit = 1'b1;
            grp = mk_err(ERR_UNTERM);
          end else begin
            phase_next = PH_ESC;
          end
        end else if (b < CTRL_LIM) begin
          emit = 1'b1;
          grp = mk_err(ERR_CONTROL);
        end else if (eoi) begin
          emit = 1'b1;
          grp = mk_err(ERR_UNTERM);
        end else begin
          emit = 1'b1;
          grp = mk_byte(b);
        end
      end
      PH_ESC: begin
        emit = 1'b1;
        phase_next = PH_BODY;
        case (b)
          CH_QUOTE: grp = mk_byte(CH_QUOTE);
          CH_BSL:   grp = mk_byte(CH_BSL);
          CH_SLASH: grp = mk_byte(CH_SLASH);
          CH_B:     grp = mk_byte(8'h08);
          CH_F:     grp = mk_byte(8'h0C);
          CH_N:     grp = mk_byte(8'h0A);
          CH_R:     grp = mk_byte(8'h0D);
          CH_T:     grp = mk_byte(8'h09);
          CH_U: begin
            if (eoi) begin
              grp = mk_err(ERR_BAD_U);
            end else begin
              emit = 1'b0;
              phase_next = PH_HEX;
              hex_count_next = '0;
              high_code_next = '0;
            end
          end
          default: grp = mk_err(ERR_BAD_ESC);
        endcase
        if (eoi && grp.kind == KIND_BYTE && emit) grp = mk_err(ERR_UNTERM);
      end
      PH_HEX: begin
        if (!hv.ok || (eoi && hex_count != 2'd3)) begin
          emit = 1'b1;
          grp = mk_err(ERR_BAD_U);
        end else begin
          high_code_next = {high_code[11:0], hv.val};
          if (hex_count != 2'd3) begin
            hex_count_next = hex_count + 2'd1;
          end else begin
            hex_count_next = '0;
            if (high_code_next >= HI_SURR_MIN && high_code_next <= HI_SURR_MAX) begin
              if (eoi) begin
                emit = 1'b1;
                grp = mk_err(ERR_LONE_HIGH);
              end else begin
                phase_next = PH_LOW_BS;
              end
            end else if (eoi) begin
              emit = 1'b1;
              grp = mk_err(ERR_UNTERM);
            end else begin
              phase_next = PH_BODY;
              emit = 1'b1;
              grp = mk_utf8({5'b00000, high_code_next});
            end
          end
        end
      end
      PH_LOW_BS: begin
        if (eoi || b != CH_BSL) begin
          emit = 1'b1;
          grp = mk_err(ERR_LONE_HIGH);
        end else begin
          phase_next = PH_LOW_U;
        end
      end
      PH_LOW_U: begin
        if (eoi || b != CH_U) begin
          emit = 1'b1;
          grp = mk_err(ERR_LONE_HIGH);
        end else begin
          phase_next = PH_LOW_HEX;
          hex_count_next = '0;
          low_code_next = '0;
          pending_bad_low_next = 1'b0;
        end
      end
      PH_LOW_HEX: begin
        if (hex_count != 2'd3) begin
          if (eoi) begin
            emit = 1'b1;
            grp = mk_err(ERR_LONE_HIGH);
          end else begin
            if (!hv.ok) pending_bad_low_next = 1'b1;
            else low_code_next = {low_code[11:0], hv.val};
            hex_count_next = hex_count + 2'd1;
          end
        end else begin
          hex_count_next = '0;
          if (pending_bad_low || !hv.ok) begin
            emit = 1'b1;
            grp = mk_err(ERR_BAD_LOW);
          end else begin
            low_code_next = {low_code[11:0], hv.val};
            if (low_code_next < LO_SURR_MIN || low_code_next > LO_SURR_MAX) begin
              emit = 1'b1;
              grp = mk_err(ERR_BAD_LOW);
            end else if (eoi) begin
              emit = 1'b1;
              grp = mk_err(ERR_UNTERM);
            end else begin
              pair_cp = SUPP_BASE + {1'b0, high_code[9:0], low_code_next[9:0]};
              phase_next = PH_BODY;
              emit = 1'b1;
              grp = mk_utf8(pair_cp);
            end
          end
        end
      end
      default: begin
        // idle, and any corrupt phase code
        phase_next = PH_IDLE;
        if (b != CH_QUOTE) begin
          emit = 1'b1;
          grp = mk_err(ERR_NO_QUOTE);
        end else if (eoi) begin
          emit = 1'b1;
          grp = mk_err(ERR_UNTERM);
        end else begin
          phase_next = PH_BODY;
          pending_bad_low_next = 1'b0;
          hex_count_next = '0;
        end
      end
    endcase
    // any error ends the string
    if (emit && grp.kind == KIND_ERR) begin
      phase_next = PH_IDLE;
      pending_bad_low_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      high_code <= '0;
      low_code <= '0;
      hex_count <= '0;
      pending_bad_low <= 1'b0;
    end else if (consume) begin
      phase <= phase_next;
      high_code <= high_code_next;
      low_code <= low_code_next;
      hex_count <= hex_count_next;
      pending_bad_low <= pending_bad_low_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/jsu_out_buf.sv -----
`default_nettype none
module jsu_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire jsu_pkg::jsu_grp_t grp_in,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             kind,
  output logic [7:0]             decoded_byte,
  output logic [2:0]             error_code,
  output logic                   last_of_run
);
  import jsu_pkg::*;

  jsu_grp_t   grp;
  logic       grp_valid;
  logic [1:0] idx;
  logic       take;
  logic       at_last;

  assign at_last  = (idx == grp.last_idx);
  assign take     = grp_valid && out_ready;
  assign can_load = !grp_valid || (take && at_last);

  assign out_valid    = grp_valid;
  assign kind         = grp.kind;
  assign decoded_byte = grp.bytes[idx];
  assign error_code   = grp.err;
  assign last_of_run  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      grp_valid <= 1'b1;
      idx <= '0;
    end else if (take) begin
      if (at_last) grp_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp <= grp_in;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_top.sv -----
`default_nettype none
// JSON string unescaper with UTF-8 output. Feed raw text one byte per word,
// starting at the opening double quote; set end_of_input on the last byte
// available. Each input word gives zero to four result words: decoded UTF-8
// bytes (kind 0), a string-closed marker (kind 1) or an error (kind 2 with
// error_code). last_of_run flags the final result word caused by an input
// byte. After a close or an error the block waits for a new opening quote.
// Throughput: one input word per cycle while each byte yields at most one
// result and out_ready is high. A \u escape that decodes to a 2, 3 or 4
// byte UTF-8 sequence holds the input while the output group register
// drains one word per cycle while out_ready is high. An accepted byte is held
// in the input register, then its results in the result group register.
module json_string_unescape_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      decoded_byte,
  output logic [2:0]      error_code,
  output logic            last_of_run
);
  import jsu_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       eoi_q;

  // decode / output handoff
  logic       can_load;
  logic       consume;
  logic       emit;
  jsu_grp_t   grp;

  // the held byte is decoded once the group register can take its results;
  // bytes with no results retire without touching the group register
  assign consume  = in_full && can_load;
  assign in_ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
      eoi_q <= end_of_input;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .b       (byte_q),
    .eoi     (eoi_q),
    .emit    (emit),
    .grp     (grp)
  );

  jsu_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (consume && emit),
    .grp_in       (grp),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .decoded_byte (decoded_byte),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire
